// File: sv/co2_ventilation_fan_controller_defines.svh
// Assertion helpers for the fan controller.
`ifndef CO2_VENTILATION_FAN_CONTROLLER_DEFINES_SVH
`define CO2_VENTILATION_FAN_CONTROLLER_DEFINES_SVH

// same-cycle implication
`define CVFC_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CVFC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/cvfc_pkg.sv
`timescale 1ns / 1ps
package cvfc_pkg;

   localparam int CO2_SAMPLE_TICKS_DEF = 64;
   localparam int DEMOIST_PERIOD_DEF   = 32768;
   localparam int REPORT_PERIOD_DEF    = 256;

   localparam logic [7:0] SEG_AUTO     = 8'h7B;
   localparam logic [7:0] SEG_OVERRIDE = 8'h3F;
   localparam logic [7:0] SEG_KICK     = 8'h75;
   localparam logic [7:0] SEG_DEMOIST  = 8'h4F;
   localparam logic [7:0] SEG_WAIT     = 8'h14;
   localparam logic [7:0] SEG_PURGE    = 8'h54;
   localparam logic [7:0] SEG_HIGH     = 8'h6B;
   localparam logic [7:0] SEG_CRIT     = 8'h36;
   localparam logic [7:0] SEG_DOT      = 8'h80;
   localparam logic [7:0] SEG_ALL      = 8'hFF;
   localparam logic [7:0] SEG_BLANK    = 8'h00;

   localparam logic [7:0]  MIN_SPEED_RST    = 8'd50;
   localparam logic [7:0]  START_SPEED_RST  = 8'd100;
   localparam logic [7:0]  START_TICKS_RST  = 8'd30;
   localparam logic [15:0] PURGE_DELAY_RST  = 16'd512;
   localparam logic [15:0] PURGE_LENGTH_RST = 16'd18000;
   localparam logic [6:0]  PERCENT_RST      = 7'd25;
   localparam logic [14:0] PERCENT_SCALE    = 15'd99;

   typedef enum logic [2:0] {
      REG_MIN_SPEED    = 3'd0,
      REG_START_SPEED  = 3'd1,
      REG_START_TICKS  = 3'd2,
      REG_PURGE_DELAY  = 3'd3,
      REG_PURGE_LENGTH = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic       co2_warn;
      logic       co2_crit;
      logic       space_open;
      logic       manual_override;
      logic [7:0] pot_manual;
      logic [7:0] pot_demoist;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] fan_duty;
      logic [6:0] fan_percent;
      logic [7:0] segments;
      logic       report_valid;
      logic [7:0] report_code;
      logic [7:0] co2_level_out;
   } rsp_payload_type;

   typedef struct packed {
      logic step;
      logic div_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic need_div;
      logic div_last;
   } status_type;

endpackage

// File: sv/cvfc_ctrl.sv
`timescale 1ns / 1ps
`include "co2_ventilation_fan_controller_defines.svh"
module cvfc_ctrl
   import cvfc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_OUT  = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.step = 1'b1;
               state_in = status.need_div ? ST_DIV : ST_OUT;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (slot_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `CVFC_ASSERT_NOW(a_step_idle, cmd.step, state_ff == ST_IDLE, "request taken while busy")
   `CVFC_ASSERT_NOW(a_load_free, cmd.out_load, !(rsp_valid_ff && rsp_stall), "result overwritten")
   `CVFC_ASSERT_NEXT(a_step_busy, cmd.step, state_ff != ST_IDLE, "no work after request")
   `CVFC_ASSERT_NEXT(a_div_end, state_ff == ST_DIV && status.div_last, state_ff == ST_OUT,
      "divide did not finish")

endmodule

// File: sv/cvfc_datapath.sv
`timescale 1ns / 1ps
module cvfc_datapath
   import cvfc_pkg::*;
#(
   parameter int CO2_SAMPLE_TICKS = CO2_SAMPLE_TICKS_DEF,
   parameter int DEMOIST_PERIOD   = DEMOIST_PERIOD_DEF,
   parameter int REPORT_PERIOD    = REPORT_PERIOD_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_write_en,
   input  logic [2:0]      csr_index,
   input  logic [15:0]     csr_wdata,
   input  req_payload_type req_data,
   output rsp_payload_type rsp_data,
   input  cmd_type         cmd,
   output status_type      status
);

   localparam int CW = (CO2_SAMPLE_TICKS > 1) ? $clog2(CO2_SAMPLE_TICKS) : 1;
   localparam int DW = (DEMOIST_PERIOD > 1) ? $clog2(DEMOIST_PERIOD) : 1;
   localparam int RW = (REPORT_PERIOD > 1) ? $clog2(REPORT_PERIOD) : 1;
   localparam logic [RW-1:0] REPORT_MATCH = RW'(100 % REPORT_PERIOD);

   typedef struct packed {
      logic [7:0] dd;
      logic [7:0] fs;
      logic [7:0] ht;
      logic [7:0] hc;
      logic       settled;
      logic       kick;
   } speed_type;

   logic [7:0]  min_ff, start_ff, sticks_ff;
   logic [15:0] pdelay_ff, plength_ff;

   logic [15:0]   sc_ff, sc_in;
   logic [CW-1:0] cc_ff, cc_in;
   logic [DW-1:0] dc_ff, dc_in;
   logic [RW-1:0] rc_ff, rc_in;
   logic [7:0]    lvl_ff, lvl_in;
   logic [4:0]    ph_ff, ph_in;
   logic [7:0]    dm_ff, dm_in;
   logic [7:0]    fs_ff, dd_ff, hc_ff, ht_ff;
   logic          poh_ff, poh_in;
   logic [6:0]    pv_ff;
   logic [7:0]    mc_ff, mc_in;
   logic [7:0]    co_ff, co_in;
   logic [7:0]    seg_ff, seg_in;
   logic          rep_ff, rep_in;
   speed_type     sp;

   logic [7:0]  rem_ff, rem_in;
   logic [14:0] q_ff, q_in;
   logic [7:0]  den_ff;
   logic [3:0]  cnt_ff;
   logic [8:0]  trial;
   logic        ge;
   rsp_payload_type rsp_ff;

   function automatic speed_type set_speed(input speed_type s, input logic [7:0] req);
      speed_type r;
      r      = s;
      r.kick = 1'b0;
      if (s.dd < min_ff && req < start_ff) begin
         if (req < min_ff) begin
            r.fs = 8'd0; r.dd = 8'd0; r.settled = 1'b1;
         end else if (sticks_ff != 8'd0) begin
            r.dd = start_ff; r.ht = req; r.hc = sticks_ff; r.kick = 1'b1;
         end else begin
            r.fs = req; r.dd = req; r.settled = 1'b1;
         end
      end else begin
         r.fs = (req < min_ff) ? 8'd0 : req;
         r.dd = r.fs;
         r.settled = 1'b1;
      end
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff     <= MIN_SPEED_RST;
         start_ff   <= START_SPEED_RST;
         sticks_ff  <= START_TICKS_RST;
         pdelay_ff  <= PURGE_DELAY_RST;
         plength_ff <= PURGE_LENGTH_RST;
      end else if (csr_write_en) begin
         unique case (csr_index)
            REG_MIN_SPEED:    min_ff     <= csr_wdata[7:0];
            REG_START_SPEED:  start_ff   <= csr_wdata[7:0];
            REG_START_TICKS:  sticks_ff  <= csr_wdata[7:0];
            REG_PURGE_DELAY:  pdelay_ff  <= csr_wdata;
            REG_PURGE_LENGTH: plength_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      logic       warn, crit, stop;
      logic [7:0] now8;
      logic [8:0] want;
      sc_in = sc_ff + 16'd1;
      cc_in = (({1'b0, cc_ff} + (CW+1)'(1)) == (CW+1)'(CO2_SAMPLE_TICKS)) ? '0 : cc_ff + CW'(1);
      dc_in = (({1'b0, dc_ff} + (DW+1)'(1)) == (DW+1)'(DEMOIST_PERIOD)) ? '0 : dc_ff + DW'(1);
      rc_in = (({1'b0, rc_ff} + (RW+1)'(1)) == (RW+1)'(REPORT_PERIOD)) ? '0 : rc_ff + RW'(1);
      if (sc_in == 16'd0) begin
         cc_in = '0; dc_in = '0; rc_in = '0;
      end
      rep_in = (rc_in == REPORT_MATCH);
      warn   = req_data.co2_warn;
      crit   = req_data.co2_crit;
      stop   = 1'b0;
      want   = '0;
      now8   = sc_in[7:0];
      lvl_in = lvl_ff;
      ph_in  = ph_ff;
      dm_in  = dm_ff;
      poh_in = poh_ff;
      mc_in  = mc_ff;
      co_in  = co_ff;
      sp     = '{dd: dd_ff, fs: fs_ff, ht: ht_ff, hc: hc_ff, settled: 1'b0, kick: 1'b0};
      if (sp.hc != 8'd0) sp.hc = sp.hc - 8'd1;
      if (sp.hc != 8'd0) begin
         seg_in = poh_ff ? SEG_ALL : SEG_KICK;
      end else begin
         if (poh_ff) begin
            poh_in = 1'b0;
         end else if (sp.dd != sp.fs || sp.ht != sp.fs) begin
            if (sp.dd == start_ff || sp.ht != sp.fs) begin
               sp.fs = sp.ht; sp.dd = sp.ht; sp.settled = 1'b1;
            end
         end
         if (cc_in == '0) begin
            if (warn && lvl_in < 8'd254) lvl_in = lvl_in + 8'd1;
            else if (crit) lvl_in = 8'd255;
            else if (!warn && !crit && lvl_in != 8'd0) lvl_in = lvl_in - 8'd1;
         end
         if (req_data.space_open) begin
            if (ph_in < 5'd2) begin
               ph_in = ph_in + 5'd16;
               dm_in = now8 + 8'd2;
            end
            if (ph_in >= 5'd16 && dm_in == now8) ph_in = 5'd2;
            if (req_data.manual_override) begin
               mc_in = SEG_OVERRIDE;
               sp    = set_speed(sp, req_data.pot_manual);
               stop  = sp.kick;
            end else begin
               want = {1'b0, min_ff} + {1'b0, lvl_in};
               if (want[8]) begin
                  if (sp.fs != 8'd255) begin
                     sp   = set_speed(sp, 8'd255);
                     stop = sp.kick;
                  end
               end else if (sp.fs != want[7:0]) begin
                  sp   = set_speed(sp, want[7:0]);
                  stop = sp.kick;
               end
               if (!stop) mc_in = SEG_AUTO;
            end
            if (!stop) co_in = warn ? SEG_HIGH : (crit ? SEG_CRIT : SEG_BLANK);
         end else begin
            mc_in = SEG_DOT;
            if (ph_in == 5'd2) begin
               ph_in = 5'd18;
               dm_in = now8 + 8'd2;
            end
            if (ph_in >= 5'd16 && dm_in == now8) ph_in = ph_in - 5'd16;
            if (ph_in == 5'd2) begin
               sc_in = '0; cc_in = '0; dc_in = '0; rc_in = '0;
               ph_in = 5'd1;
               co_in = SEG_WAIT;
            end
            if (ph_in == 5'd1) begin
               if (sc_in >= pdelay_ff) begin
                  sp    = set_speed(sp, 8'd255);
                  co_in = SEG_PURGE;
               end
               if (sc_in >= plength_ff) begin
                  sp    = set_speed(sp, 8'd0);
                  co_in = SEG_BLANK;
                  ph_in = 5'd0;
               end
            end
            if (ph_in == 5'd0) begin
               co_in = SEG_BLANK;
               if (16'(dc_in) < {5'd0, req_data.pot_demoist, 3'd0} && lvl_in != 8'd255) begin
                  if (sp.fs != start_ff) sp = set_speed(sp, start_ff);
                  co_in = SEG_DEMOIST;
               end else if (sp.fs != 8'd0) begin
                  sp = set_speed(sp, 8'd0);
               end
            end
         end
         if (sp.hc != 8'd0) begin
            seg_in = SEG_KICK;
         end else begin
            unique case (sc_in[3:2])
               2'd0:    seg_in = SEG_DOT;
               2'd1:    seg_in = mc_in;
               2'd2:    seg_in = co_in;
               default: seg_in = SEG_BLANK;
            endcase
         end
      end
   end

   assign status.need_div = sp.settled && sp.fs > min_ff;
   assign status.div_last = (cnt_ff == 4'd0);

   assign trial  = {rem_ff, q_ff[14]};
   assign ge     = trial >= {1'b0, den_ff};
   assign rem_in = ge ? 8'(trial - {1'b0, den_ff}) : trial[7:0];
   assign q_in   = {q_ff[13:0], ge};

   always_ff @(posedge clock) begin
      if (reset) begin
         sc_ff  <= '0;
         cc_ff  <= '0;
         dc_ff  <= '0;
         rc_ff  <= '0;
         lvl_ff <= '0;
         ph_ff  <= '0;
         dm_ff  <= '0;
         fs_ff  <= START_SPEED_RST;
         dd_ff  <= START_SPEED_RST;
         hc_ff  <= START_TICKS_RST;
         ht_ff  <= START_SPEED_RST;
         poh_ff <= 1'b1;
         pv_ff  <= PERCENT_RST;
         mc_ff  <= SEG_AUTO;
         co_ff  <= SEG_BLANK;
         cnt_ff <= '0;
      end else if (cmd.step) begin
         sc_ff  <= sc_in;
         cc_ff  <= cc_in;
         dc_ff  <= dc_in;
         rc_ff  <= rc_in;
         lvl_ff <= lvl_in;
         ph_ff  <= ph_in;
         dm_ff  <= dm_in;
         fs_ff  <= sp.fs;
         dd_ff  <= sp.dd;
         hc_ff  <= sp.hc;
         ht_ff  <= sp.ht;
         poh_ff <= poh_in;
         mc_ff  <= mc_in;
         co_ff  <= co_in;
         cnt_ff <= 4'd14;
         if (sp.settled) begin
            if (sp.fs == 8'd0) pv_ff <= 7'd0;
            else if (sp.fs <= min_ff) pv_ff <= 7'd1;
         end
      end else if (cmd.div_step) begin
         cnt_ff <= cnt_ff - 4'd1;
         if (cnt_ff == 4'd0) pv_ff <= q_in[6:0] + 7'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.step) begin
         seg_ff <= seg_in;
         rep_ff <= rep_in;
         rem_ff <= '0;
         q_ff   <= 15'(sp.fs - min_ff) * PERCENT_SCALE;
         den_ff <= ~min_ff;
      end else if (cmd.div_step) begin
         rem_ff <= rem_in;
         q_ff   <= q_in;
      end
      if (cmd.out_load) begin
         rsp_ff.fan_duty      <= dd_ff;
         rsp_ff.fan_percent   <= pv_ff;
         rsp_ff.segments      <= seg_ff;
         rsp_ff.report_valid  <= rep_ff;
         rsp_ff.report_code   <= (mc_ff == SEG_DOT) ? co_ff : mc_ff;
         rsp_ff.co2_level_out <= lvl_ff;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// File: sv/co2_ventilation_fan_controller.sv
// Flow: a request is taken while idle, then its result is loaded into the output register;
// when the fan speed changes to a running value, a 15-step percent divide runs in between.
// One request at a time; a new request is taken once the previous result is in the output
// register, and a result waits while the previous one is still stalled at the output.
// Reset (synchronous): registers at defaults, fan at start speed under a power-on hold.
`timescale 1ns / 1ps
module co2_ventilation_fan_controller
   import cvfc_pkg::*;
#(
   parameter int CO2_SAMPLE_TICKS = CO2_SAMPLE_TICKS_DEF,
   parameter int DEMOIST_PERIOD   = DEMOIST_PERIOD_DEF,
   parameter int REPORT_PERIOD    = REPORT_PERIOD_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_write_en,
   input  logic [2:0]      csr_index,
   input  logic [15:0]     csr_wdata,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_data
);

   cmd_type    cmd;
   status_type status;

   cvfc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   cvfc_datapath #(
      .CO2_SAMPLE_TICKS (CO2_SAMPLE_TICKS),
      .DEMOIST_PERIOD   (DEMOIST_PERIOD),
      .REPORT_PERIOD    (REPORT_PERIOD)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_data     (req_data),
      .rsp_data     (rsp_data),
      .cmd          (cmd),
      .status       (status)
   );

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
   import cvfc_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_en = 1'b0;
   logic [2:0] csr_index = '0;
   logic [15:0] csr_wdata = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   req_payload_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_payload_type rsp_data;

   co2_ventilation_fan_controller i_dut (
      .clock(clock), .reset(reset),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // fan model state
   logic [7:0] min_speed, start_speed, start_ticks;
   logic [15:0] purge_delay, purge_length;
   logic [15:0] slow_clock;
   logic [7:0] co2_level, space_phase, debounce_mark;
   logic [7:0] fan_setting, drive_duty, hold_count, hold_target;
   logic power_on_hold;
   logic [6:0] percent_value;
   logic [7:0] mode_code, co2_code;

   rsp_payload_type fan_expected[$];
   int mismatches = 0;
   int responses = 0;
   bit quiet = 1'b0;
   bit rsp_idle_on = 1'b1;

   function automatic logic [6:0] percent_of(logic [7:0] f);
      int unsigned span;
      if (f == 0) return 7'd0;
      if (f <= min_speed) return 7'd1;
      span = 255 - min_speed;
      return 7'((99 * (int'(f) - int'(min_speed))) / span + 1);
   endfunction

   function automatic void settle(logic [7:0] f);
      fan_setting = f;
      drive_duty = f;
      percent_value = percent_of(f);
   endfunction

   function automatic bit set_speed(logic [7:0] want);
      if (drive_duty < min_speed && want < start_speed) begin
         if (want < min_speed) settle(8'd0);
         else if (start_ticks > 0) begin
            drive_duty = start_speed;
            hold_target = want;
            hold_count = start_ticks;
            return 1'b1;
         end else settle(want);
      end else settle(want < min_speed ? 8'd0 : want);
      return 1'b0;
   endfunction

   function automatic void fan_reset();
      min_speed = MIN_SPEED_RST;
      start_speed = START_SPEED_RST;
      start_ticks = START_TICKS_RST;
      purge_delay = PURGE_DELAY_RST;
      purge_length = PURGE_LENGTH_RST;
      slow_clock = 0;
      co2_level = 0;
      space_phase = 0;
      debounce_mark = 0;
      settle(start_speed < min_speed ? 8'd0 : start_speed);
      hold_count = start_ticks;
      hold_target = start_speed;
      power_on_hold = 1'b1;
      mode_code = SEG_AUTO;
      co2_code = 0;
   endfunction

   function automatic void control_pass(req_payload_type r);
      logic [7:0] now8;
      int unsigned want;
      now8 = slow_clock[7:0];
      if (slow_clock % CO2_SAMPLE_TICKS_DEF == 0) begin
         if (r.co2_warn && co2_level < 254) co2_level++;
         else if (r.co2_crit) co2_level = 8'd255;
         else if (!r.co2_warn && !r.co2_crit && co2_level > 0) co2_level--;
      end
      if (r.space_open) begin
         if (space_phase < 2) begin
            space_phase = space_phase + 8'd16;
            debounce_mark = now8 + 8'd2;
         end
         if (space_phase >= 16 && debounce_mark == now8) space_phase = 2;
         if (r.manual_override) begin
            mode_code = SEG_OVERRIDE;
            if (set_speed(r.pot_manual)) return;
         end else begin
            want = min_speed + co2_level;
            if (want > 255) begin
               if (fan_setting < 255 && set_speed(8'd255)) return;
            end else if (fan_setting != want) begin
               if (set_speed(8'(want))) return;
            end
            mode_code = SEG_AUTO;
         end
         co2_code = r.co2_warn ? SEG_HIGH : (r.co2_crit ? SEG_CRIT : 8'd0);
      end else begin
         mode_code = SEG_DOT;
         if (space_phase == 2) begin
            space_phase = 18;
            debounce_mark = now8 + 8'd2;
         end
         if (space_phase >= 16 && debounce_mark == now8) space_phase = space_phase - 8'd16;
         if (space_phase == 2) begin
            slow_clock = 0;
            space_phase = 1;
            co2_code = SEG_WAIT;
         end
         if (space_phase == 1) begin
            if (slow_clock >= purge_delay) begin
               void'(set_speed(8'd255));
               co2_code = SEG_PURGE;
            end
            if (slow_clock >= purge_length) begin
               void'(set_speed(8'd0));
               co2_code = 0;
               space_phase = 0;
            end
         end
         if (space_phase == 0) begin
            co2_code = 0;
            if (slow_clock % DEMOIST_PERIOD_DEF < int'(r.pot_demoist) * 8 && co2_level < 255) begin
               if (fan_setting != start_speed) void'(set_speed(start_speed));
               co2_code = SEG_DEMOIST;
            end else if (fan_setting != 0) void'(set_speed(8'd0));
         end
      end
   endfunction

   function automatic rsp_payload_type fan_tick(req_payload_type r);
      rsp_payload_type o;
      logic [7:0] seg;
      logic report;
      slow_clock = slow_clock + 16'd1;
      report = (slow_clock % REPORT_PERIOD_DEF) == (100 % REPORT_PERIOD_DEF);
      if (hold_count > 0) hold_count--;
      if (hold_count > 0) seg = power_on_hold ? SEG_ALL : SEG_KICK;
      else begin
         if (power_on_hold) power_on_hold = 1'b0;
         else if (drive_duty != fan_setting || hold_target != fan_setting) begin
            if (drive_duty == start_speed || hold_target != fan_setting) begin
               settle(hold_target);
               hold_target = fan_setting;
            end
         end
         control_pass(r);
         if (hold_count > 0) seg = SEG_KICK;
         else begin
            case (slow_clock[3:2])
               2'd0: seg = SEG_DOT;
               2'd1: seg = mode_code;
               2'd2: seg = co2_code;
               default: seg = SEG_BLANK;
            endcase
         end
      end
      o.fan_duty = drive_duty;
      o.fan_percent = percent_value;
      o.segments = seg;
      o.report_valid = report;
      o.report_code = (mode_code == SEG_DOT) ? co2_code : mode_code;
      o.co2_level_out = co2_level;
      return o;
   endfunction

   task automatic send_request(req_payload_type r, bit pinned, rsp_payload_type pin);
      rsp_payload_type e;
      int gap;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         gap = $urandom_range(1, 5);
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      e = fan_tick(r);
      if (pinned && e != pin) begin
         mismatches++;
         if (mismatches <= 10)
            $display("table row disagrees with predictor: %h vs %h", pin, e);
      end
      fan_expected.push_back(pinned ? pin : e);
   endtask

   task automatic drain();
      int guard;
      guard = 0;
      req_valid <= 1'b0;
      while (fan_expected.size() != 0 && guard < 10000) begin
         @(posedge clock);
         guard++;
      end
      repeat (40) @(posedge clock);
   endtask

   task automatic write_reg(reg_index_type idx, logic [15:0] v);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      case (idx)
         REG_MIN_SPEED: min_speed = v[7:0];
         REG_START_SPEED: start_speed = v[7:0];
         REG_START_TICKS: start_ticks = v[7:0];
         REG_PURGE_DELAY: purge_delay = v;
         REG_PURGE_LENGTH: purge_length = v;
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         responses++;
         if (fan_expected.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %h", rsp_data);
         end else begin
            rsp_payload_type e;
            e = fan_expected.pop_front();
            if (e != rsp_data) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp duty %0d pct %0d seg %h rep %0d code %h co2 %0d,",
                     e.fan_duty, e.fan_percent, e.segments, e.report_valid, e.report_code,
                     e.co2_level_out,
                     " got duty %0d pct %0d seg %h rep %0d code %h co2 %0d",
                     rsp_data.fan_duty, rsp_data.fan_percent,
                     rsp_data.segments, rsp_data.report_valid, rsp_data.report_code,
                     rsp_data.co2_level_out);
            end
         end
      end
   end

   int stall_left = 0;
   always @(posedge clock) begin
      if (quiet || !rsp_idle_on) rsp_stall <= 1'b0;
      else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 4);
         rsp_stall <= 1'b1;
      end else rsp_stall <= 1'b0;
   end

   function automatic req_payload_type mk(bit w, bit c, bit o, bit ov, logic [7:0] pm,
                                          logic [7:0] pd);
      req_payload_type r;
      r.co2_warn = w;
      r.co2_crit = c;
      r.space_open = o;
      r.manual_override = ov;
      r.pot_manual = pm;
      r.pot_demoist = pd;
      return r;
   endfunction

   function automatic req_payload_type rand_req(bit open_bias);
      req_payload_type r;
      r = req_payload_type'(20'($urandom));
      if (open_bias) r.space_open = ($urandom_range(0, 9) != 0);
      return r;
   endfunction

   initial begin
      #2000000;
      $display("co2_ventilation_fan_controller test failed");
      $finish;
   end

   initial begin
      req_payload_type dir_req[20];
      bit dir_pin[20];
      rsp_payload_type dir_rsp[20];
      rsp_payload_type pin;
      int n;
      int k;
      fan_reset();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // power-on hold rows: duty at start speed, all segments lit
      for (k = 0; k < 20; k++) begin
         dir_pin[k] = 1'b0;
         dir_req[k] = mk(k[0], k[1], k[2], k[3], 8'(k * 13), 8'(255 - k));
      end
      dir_req[0] = mk(1, 1, 1, 1, 8'hFF, 8'hFF);
      dir_req[1] = mk(0, 0, 0, 0, 8'h00, 8'h00);
      pin.fan_duty = START_SPEED_RST;
      pin.fan_percent = PERCENT_RST;
      pin.segments = SEG_ALL;
      pin.report_valid = 1'b0;
      pin.report_code = SEG_AUTO;
      pin.co2_level_out = 8'd0;
      dir_pin[0] = 1'b1;
      dir_rsp[0] = pin;
      dir_pin[1] = 1'b1;
      dir_rsp[1] = pin;
      for (k = 0; k < 20; k++) send_request(dir_req[k], dir_pin[k], dir_rsp[k]);
      // finish the hold, then manual override at full, zero and a mid speed with the space open
      for (k = 0; k < 12; k++) send_request(mk(0, 0, 1, 0, 0, 0), 0, pin);
      send_request(mk(0, 0, 1, 1, 8'hFF, 0), 0, pin);
      send_request(mk(0, 0, 1, 1, 8'h00, 0), 0, pin);
      send_request(mk(0, 0, 1, 1, 8'd60, 0), 0, pin);
      drain();

      n = 0;
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: begin
               write_reg(REG_MIN_SPEED, 16'd0);
               write_reg(REG_START_SPEED, 16'd255);
               write_reg(REG_START_TICKS, 16'd0);
               write_reg(REG_PURGE_DELAY, 16'd0);
               write_reg(REG_PURGE_LENGTH, 16'd20);
            end
            1: begin
               write_reg(REG_MIN_SPEED, 16'd254);
               write_reg(REG_START_SPEED, 16'd0);
               write_reg(REG_START_TICKS, 16'd255);
               write_reg(REG_PURGE_DELAY, 16'hFFFF);
               write_reg(REG_PURGE_LENGTH, 16'hFFFF);
            end
            default: begin
               write_reg(REG_MIN_SPEED, 16'($urandom_range(0, 120)));
               write_reg(REG_START_SPEED, 16'($urandom_range(60, 255)));
               write_reg(REG_START_TICKS, 16'($urandom_range(0, 6)));
               write_reg(REG_PURGE_DELAY, 16'($urandom_range(0, 15)));
               write_reg(REG_PURGE_LENGTH, 16'($urandom_range(5, 40)));
            end
         endcase
         csr_write_en <= 1'b0;
         for (k = 0; k < 90; k++) begin
            req_payload_type r;
            if (phase >= 2 && k % 30 < 6) begin
               // close sequence: space held closed after an optional open first request
               r = rand_req(0);
               r.space_open = (k % 30 == 0 && $urandom_range(0, 1));
            end else r = rand_req(phase != 1);
            if (phase == 4 && k > 60) quiet = 1'b1;
            send_request(r, 0, pin);
            n++;
         end
         if (phase == 2) drain();
         else drain();
      end

      drain();
      $display("%0d requests, %0d responses, five register settings incl. extremes", n + 35,
         responses);
      if (mismatches == 0 && fan_expected.size() == 0)
         $display("co2_ventilation_fan_controller test passed");
      else $display("co2_ventilation_fan_controller test failed");
      $finish;
   end
endmodule
